[rtl/kwrm_pkg.sv]
// ----------------------------------------------------------------------------
// kwrm_pkg
// Types and codes shared by the k-way record merge core.
// ----------------------------------------------------------------------------
package kwrm_pkg;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_DONE   = 1'b1;

    localparam logic [1:0] ADDR_LISTS_IN_USE = 2'd0;

    typedef struct packed {
        logic        func;
        logic [2:0]  list_index;
        logic [31:0] rec_id;
        logic [11:0] rec_year;
        logic [15:0] university_rank;
        logic [15:0] batch_rank;
    } kwrm_request_t;

    typedef struct packed {
        logic [31:0] out_rec_id;
        logic [11:0] out_rec_year;
        logic [15:0] out_university_rank;
        logic [15:0] out_batch_rank;
        logic [2:0]  refill_list;
        logic        merge_last;
    } kwrm_result_t;

    typedef struct packed {
        logic [11:0] rec_year;
        logic [15:0] university_rank;
        logic [15:0] batch_rank;
    } kwrm_key_t;

    typedef struct packed {
        logic [31:0] rec_id;
        kwrm_key_t   key;
    } kwrm_head_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } kwrm_state_t;

endpackage

[rtl/k_way_record_merge_core.sv]
// ----------------------------------------------------------------------------
// k_way_record_merge_core
// Merges up to MAX_LISTS sorted record lists into one ascending stream.
//
// A request is taken at a rising edge with start high and busy low. It either
// delivers the next record of list list_index (func = record) or marks that
// list exhausted (func = done). Once every list in use that is not exhausted
// holds a head, the least head (year, then university rank, then batch rank,
// lower list first) appears on result for one cycle with result_valid high,
// and refill_list names the list to deliver next. The receiver cannot stall.
// Sequence: a request is taken in an idle cycle. With no result due, busy
// stays high only for the check of the heads. With a result due, busy stays
// high while the core checks the heads, scans the head memory one entry a
// cycle through a single key comparator, and presents the result.
// Reset sets lists_in_use to 8 and clears all heads and exhausted marks. A
// write to lists_in_use over the APB port (byte address 0) starts a new merge.
// ----------------------------------------------------------------------------
module k_way_record_merge_core #(
    parameter int MAX_LISTS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  kwrm_pkg::kwrm_request_t request,
    output logic                    result_valid,
    output kwrm_pkg::kwrm_result_t  result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IDX_W = $clog2(MAX_LISTS);
    localparam int N_W   = $clog2(MAX_LISTS + 1);

    kwrm_pkg::kwrm_state_t state_reg;
    kwrm_pkg::kwrm_state_t state_next;
    logic [3:0]            lists_reg;
    logic [3:0]            lists_next;
    logic [MAX_LISTS-1:0]  present_reg;
    logic [MAX_LISTS-1:0]  present_next;
    logic [MAX_LISTS-1:0]  done_reg;
    logic [MAX_LISTS-1:0]  done_next;
    logic [N_W-1:0]        cnt_reg;
    logic [N_W-1:0]        cnt_next;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      rd_idx_next;

    logic [N_W-1:0]        n_act;
    logic [MAX_LISTS-1:0]  active_mask;
    logic [MAX_LISTS-1:0]  sel_onehot;
    logic [MAX_LISTS-1:0]  best_onehot;
    logic                  accept;
    logic                  cfg_wr;
    logic                  in_range;
    logic                  slot_free;
    logic                  store;
    logic                  awaited;
    logic                  rd_en;
    logic                  scan_clear;
    logic                  scan_valid;
    kwrm_pkg::kwrm_head_t  wr_head;
    kwrm_pkg::kwrm_head_t  rd_head;
    kwrm_pkg::kwrm_head_t  best_head;
    logic [IDX_W-1:0]      best_idx;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == kwrm_pkg::ADDR_LISTS_IN_USE);
    assign pready = 1'b1;
    assign prdata = {28'd0, lists_reg};
    assign busy   = (state_reg != kwrm_pkg::ST_IDLE);

    always_comb
    begin
        int n;
        n = int'(lists_reg);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > MAX_LISTS)
        begin
            n = MAX_LISTS;
        end
        n_act = N_W'(n);
    end

    always_comb
    begin
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            active_mask[i] = (8'(i) < 8'(n_act));
            sel_onehot[i]  = (8'(request.list_index) == 8'(i));
            best_onehot[i] = (best_idx == IDX_W'(i));
        end
    end

    assign in_range  = (8'(request.list_index) < 8'(n_act));
    assign slot_free = !(|(present_reg & sel_onehot)) && !(|(done_reg & sel_onehot));
    assign store     = accept && in_range && (request.func == kwrm_pkg::FUNC_RECORD)
                       && slot_free;
    assign awaited   = |(active_mask & ~present_reg & ~done_reg);

    assign wr_head.rec_id              = request.rec_id;
    assign wr_head.key.rec_year        = request.rec_year;
    assign wr_head.key.university_rank = request.university_rank;
    assign wr_head.key.batch_rank      = request.batch_rank;

    always_comb
    begin
        lists_next   = lists_reg;
        present_next = present_reg;
        done_next    = done_reg;
        if (cfg_wr)
        begin
            lists_next   = pwdata[3:0];
            present_next = '0;
            done_next    = '0;
        end
        else if (accept && in_range)
        begin
            if (request.func == kwrm_pkg::FUNC_DONE)
            begin
                done_next = done_reg | sel_onehot;
            end
            else if (slot_free)
            begin
                present_next = present_reg | sel_onehot;
            end
        end
        else if (state_reg == kwrm_pkg::ST_EMIT)
        begin
            present_next = present_reg & ~best_onehot;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_idx_next  = rd_idx_reg;
        rd_en        = 1'b0;
        scan_clear   = 1'b0;
        scan_valid   = 1'b0;
        result_valid = 1'b0;
        case (state_reg)
            kwrm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = kwrm_pkg::ST_CHECK;
                end
            end
            kwrm_pkg::ST_CHECK:
            begin
                if (!awaited && (|present_reg))
                begin
                    rd_en       = 1'b1;
                    scan_clear  = 1'b1;
                    rd_idx_next = '0;
                    cnt_next    = N_W'(1);
                    state_next  = kwrm_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = kwrm_pkg::ST_IDLE;
                end
            end
            kwrm_pkg::ST_SCAN:
            begin
                scan_valid = present_reg[rd_idx_reg];
                if (cnt_reg < n_act)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + N_W'(1);
                end
                else
                begin
                    state_next = kwrm_pkg::ST_EMIT;
                end
            end
            kwrm_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                state_next   = kwrm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kwrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kwrm_pkg::ST_IDLE;
            lists_reg   <= 4'd8;
            present_reg <= '0;
            done_reg    <= '0;
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            lists_reg   <= lists_next;
            present_reg <= present_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    kwrm_head_mem #(
        .DEPTH (MAX_LISTS)
    ) u_head_mem (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (IDX_W'(request.list_index)),
        .wr_data (wr_head),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_next),
        .rd_data (rd_head)
    );

    kwrm_min_scan #(
        .IDX_W (IDX_W)
    ) u_min_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .valid     (scan_valid),
        .idx       (rd_idx_reg),
        .head      (rd_head),
        .best_head (best_head),
        .best_idx  (best_idx)
    );

    assign result.out_rec_id          = best_head.rec_id;
    assign result.out_rec_year        = best_head.key.rec_year;
    assign result.out_university_rank = best_head.key.university_rank;
    assign result.out_batch_rank      = best_head.key.batch_rank;
    assign result.refill_list         = 3'(best_idx);
    assign result.merge_last          = ((present_reg & ~best_onehot) == '0)
                                        && ((done_reg & active_mask) == active_mask);

endmodule

[rtl/kwrm_head_mem.sv]
// ----------------------------------------------------------------------------
// kwrm_head_mem
// Head record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kwrm_head_mem #(
    parameter int DEPTH = 8
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  kwrm_pkg::kwrm_head_t      wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output kwrm_pkg::kwrm_head_t      rd_data
);

    kwrm_pkg::kwrm_head_t mem [DEPTH];
    kwrm_pkg::kwrm_head_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/kwrm_min_scan.sv]
// ----------------------------------------------------------------------------
// kwrm_min_scan
// Running minimum over the heads read one per cycle; ties keep the earlier.
// ----------------------------------------------------------------------------
module kwrm_min_scan #(
    parameter int IDX_W = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic                  valid,
    input  logic [IDX_W-1:0]      idx,
    input  kwrm_pkg::kwrm_head_t  head,
    output kwrm_pkg::kwrm_head_t  best_head,
    output logic [IDX_W-1:0]      best_idx
);

    logic                 found_reg;
    logic                 found_next;
    kwrm_pkg::kwrm_head_t best_head_reg;
    kwrm_pkg::kwrm_head_t best_head_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;

    always_comb
    begin
        found_next     = found_reg;
        best_head_next = best_head_reg;
        best_idx_next  = best_idx_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (valid && (!found_reg || (head.key < best_head_reg.key)))
        begin
            found_next     = 1'b1;
            best_head_next = head;
            best_idx_next  = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_head_reg <= best_head_next;
        best_idx_reg  <= best_idx_next;
    end

    assign best_head = best_head_reg;
    assign best_idx  = best_idx_reg;

endmodule

[verif/tb_k_way_record_merge_core.sv]
// ----------------------------------------------------------------------------
// tb_k_way_record_merge_core
// Drives sorted record lists into the k-way merge core and checks every
// emitted record against a cycle-free predictor of the merge: head slots,
// exhausted marks, least-head selection with ties to the lower list, and the
// final-record flag. Runs directed corner cases, then randomised merges over
// many list counts, some with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb_k_way_record_merge_core;

    localparam int LISTS         = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 400;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    kwrm_pkg::kwrm_request_t request;
    logic                    result_valid;
    kwrm_pkg::kwrm_result_t  result;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [1:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    logic [3:0]              lists_setting;
    logic [31:0]             held_id [LISTS];
    kwrm_pkg::kwrm_key_t     held_key [LISTS];
    logic [LISTS-1:0]        head_valid;
    logic [LISTS-1:0]        list_closed;

    kwrm_pkg::kwrm_result_t  merge_expect_q[$];
    kwrm_pkg::kwrm_result_t  want;
    int                      error_count = 0;
    int                      sent_count  = 0;
    bit                      gaps_on     = 1'b1;

    k_way_record_merge_core #(.MAX_LISTS(LISTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        error_count++;
        $display("[%0t] mismatch: %s expected %0h got %0h", $time, what, exp_val, got_val);
    endtask

    function automatic int lists_taking_part();
        int n;
        n = lists_setting;
        if (n == 0) n = 1;
        if (n > LISTS) n = LISTS;
        return n;
    endfunction

    function automatic void clear_merge();
        head_valid  = '0;
        list_closed = '0;
    endfunction

    // advance the merge by one request; returns 1 when a record is emitted
    function automatic bit merge_step(input kwrm_pkg::kwrm_request_t req,
                                      output kwrm_pkg::kwrm_result_t res);
        int n;
        int idx;
        int best;
        bit found;
        bit waiting;
        bit all_closed;
        n = lists_taking_part();
        idx = req.list_index;
        best = 0;
        found = 1'b0;
        waiting = 1'b0;
        all_closed = 1'b1;
        res = '0;
        if (idx < n)
        begin
            if (req.func == kwrm_pkg::FUNC_RECORD)
            begin
                if (!head_valid[idx] && !list_closed[idx])
                begin
                    held_id[idx]  = req.rec_id;
                    held_key[idx] = '{req.rec_year, req.university_rank, req.batch_rank};
                    head_valid[idx] = 1'b1;
                end
            end
            else
            begin
                list_closed[idx] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
            if (!head_valid[i] && !list_closed[i]) waiting = 1'b1;
        if (waiting) return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (head_valid[i] && (!found || held_key[i] < held_key[best]))
            begin
                best = i;
                found = 1'b1;
            end
        end
        if (!found) return 1'b0;
        head_valid[best] = 1'b0;
        for (int i = 0; i < n; i++)
            if (!list_closed[i]) all_closed = 1'b0;
        res.out_rec_id          = held_id[best];
        res.out_rec_year        = held_key[best].rec_year;
        res.out_university_rank = held_key[best].university_rank;
        res.out_batch_rank      = held_key[best].batch_rank;
        res.refill_list         = 3'(best);
        res.merge_last          = (head_valid == '0) && all_closed;
        return 1'b1;
    endfunction

    function automatic kwrm_pkg::kwrm_request_t make_request(input logic func,
                                                             input logic [2:0] list,
                                                             input logic [31:0] id,
                                                             input logic [11:0] year,
                                                             input logic [15:0] urank,
                                                             input logic [15:0] brank);
        kwrm_pkg::kwrm_request_t req;
        req.func            = func;
        req.list_index      = list;
        req.rec_id          = id;
        req.rec_year        = year;
        req.university_rank = urank;
        req.batch_rank      = brank;
        return req;
    endfunction

    function automatic kwrm_pkg::kwrm_request_t random_request();
        return make_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                            12'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    function automatic kwrm_pkg::kwrm_key_t next_key(input kwrm_pkg::kwrm_key_t prev);
        logic [44:0] sum;
        logic [43:0] step;
        case ($urandom_range(0, 3))
            0: step = '0;
            1: step = 44'($urandom_range(1, 3));
            2: step = 44'($urandom_range(1, 3)) << 16;
            default: step = 44'($urandom_range(1, 3)) << 32;
        endcase
        sum = {1'b0, prev} + {1'b0, step};
        if (sum[44])
            return '1;
        return kwrm_pkg::kwrm_key_t'(sum[43:0]);
    endfunction

    task automatic send_request(input kwrm_pkg::kwrm_request_t req);
        kwrm_pkg::kwrm_result_t res;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (merge_step(req, res))
            merge_expect_q = {merge_expect_q, res};
        sent_count++;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // hold requests until every awaited record has come and the core is quiet
    task automatic settle_block();
        int                     waited;
        kwrm_pkg::kwrm_result_t lost;
        waited = 0;
        start <= 1'b0;
        while (merge_expect_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        while (merge_expect_q.size() != 0)
        begin
            lost = merge_expect_q.pop_front();
            report_mismatch("record never emitted, id", lost.out_rec_id, 32'h0);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_list_count(input logic [3:0] value);
        settle_block();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= kwrm_pkg::ADDR_LISTS_IN_USE;
        pwdata  <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lists_setting = value;
        clear_merge();
    endtask

    task automatic run_merge(input logic [3:0] setting, input bit with_gaps);
        kwrm_pkg::kwrm_request_t feed_q[LISTS][$];
        int                      pick_from[$];
        kwrm_pkg::kwrm_key_t     key;
        int                      n;
        int                      pick;
        write_list_count(setting);
        gaps_on = with_gaps;
        n = lists_taking_part();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                key.rec_year        = 12'($urandom_range(0, 2));
                key.university_rank = 16'($urandom_range(0, 2));
                key.batch_rank      = 16'($urandom_range(0, 3));
            end
            else
            begin
                key.rec_year        = 12'($urandom);
                key.university_rank = 16'($urandom);
                key.batch_rank      = 16'($urandom);
            end
            repeat ($urandom_range(0, 6))
            begin
                feed_q[i] = {feed_q[i], make_request(kwrm_pkg::FUNC_RECORD, 3'(i), $urandom,
                                                     key.rec_year, key.university_rank,
                                                     key.batch_rank)};
                key = next_key(key);
            end
        end
        forever
        begin
            pick_from.delete();
            for (int i = 0; i < n; i++)
                if (!head_valid[i] && !list_closed[i]) pick_from = {pick_from, i};
            if (pick_from.size() == 0 && head_valid == '0)
                break;
            if ($urandom_range(0, 11) == 0)
                send_request(random_request());
            else if (pick_from.size() != 0)
            begin
                pick = pick_from[$urandom_range(0, pick_from.size() - 1)];
                if (feed_q[pick].size() != 0)
                    send_request(feed_q[pick].pop_front());
                else
                    send_request(make_request(kwrm_pkg::FUNC_DONE, 3'(pick), $urandom,
                                              12'($urandom), 16'($urandom), 16'($urandom)));
            end
            else
            begin
                // drain held heads by repeating exhaustion on a closed list
                for (int i = 0; i < n; i++)
                    if (list_closed[i]) pick_from = {pick_from, i};
                pick = (pick_from.size() != 0) ?
                       pick_from[$urandom_range(0, pick_from.size() - 1)] : 0;
                send_request(make_request(kwrm_pkg::FUNC_DONE, 3'(pick), $urandom,
                                          12'($urandom), 16'($urandom), 16'($urandom)));
            end
        end
    endtask

    task automatic test_default_lists();
        gaps_on = 1'b1;
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd0, 32'h0, 12'h0, 16'h0, 16'h0));
        for (int i = 1; i < 7; i++)
            send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'(i), $urandom, 12'(i),
                                      16'h8000, 16'h7fff));
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd7, 32'hffff_ffff, 12'hfff,
                                  16'hffff, 16'hffff));
    endtask

    task automatic test_special_cases();
        write_list_count(4'd3);
        gaps_on = 1'b1;
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd0, 32'hffff_ffff, 12'hfff,
                                  16'hffff, 16'hffff));
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd0, 32'h1111_1111, 12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd5, 32'h5555_5555, 12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_DONE,   3'd6, 32'h6666_6666, 12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd1, 32'h0000_0001, 12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd2, 32'h0000_0002, 12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd1, 32'h0000_0003, 12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_DONE,   3'd2, 32'h0,         12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_RECORD, 3'd2, 32'h0000_0004, 12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_DONE,   3'd1, 32'h0,         12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_DONE,   3'd1, 32'h0,         12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_DONE,   3'd0, 32'h0,         12'h000,
                                  16'h0000, 16'h0000));
        send_request(make_request(kwrm_pkg::FUNC_DONE,   3'd0, 32'h0,         12'h000,
                                  16'h0000, 16'h0000));
    endtask

    task automatic test_random_merges();
        logic [3:0] first_settings [4] = '{4'd0, 4'd15, 4'd1, 4'd8};
        int         merge_no;
        merge_no = 0;
        while (sent_count < 850)
        begin
            run_merge((merge_no < 4) ? first_settings[merge_no] : 4'($urandom_range(0, 15)),
                      $urandom_range(0, 3) != 0);
            merge_no++;
        end
    endtask

    task automatic test_steady_merges();
        while (sent_count < 950)
            run_merge(4'($urandom_range(0, 15)), 1'b0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (merge_expect_q.size() == 0)
                report_mismatch("record with none awaited, id", 32'h0, result.out_rec_id);
            else
            begin
                want = merge_expect_q.pop_front();
                if (result.out_rec_id !== want.out_rec_id)
                    report_mismatch("out_rec_id", want.out_rec_id, result.out_rec_id);
                if (result.out_rec_year !== want.out_rec_year)
                    report_mismatch("out_rec_year", 32'(want.out_rec_year),
                                    32'(result.out_rec_year));
                if (result.out_university_rank !== want.out_university_rank)
                    report_mismatch("out_university_rank", 32'(want.out_university_rank),
                                    32'(result.out_university_rank));
                if (result.out_batch_rank !== want.out_batch_rank)
                    report_mismatch("out_batch_rank", 32'(want.out_batch_rank),
                                    32'(result.out_batch_rank));
                if (result.refill_list !== want.refill_list)
                    report_mismatch("refill_list", 32'(want.refill_list),
                                    32'(result.refill_list));
                if (result.merge_last !== want.merge_last)
                    report_mismatch("merge_last", 32'(want.merge_last), 32'(result.merge_last));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        lists_setting = 4'd8;
        clear_merge();
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= kwrm_pkg::ADDR_LISTS_IN_USE;
        pwdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_lists();
        test_special_cases();
        test_random_merges();
        test_steady_merges();
        settle_block();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
